### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop_s) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop_s)) \
        else $error("assertion failed");

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr_s) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr_s)) \
        else $error("forbidden condition seen");

`endif

### rtl/enms_pkg.sv
// ----------------------------------------------------------------------------
// Edge non-maximum suppression package
// Shared constants, register indexes and the gradient direction type.
// ----------------------------------------------------------------------------
package enms_pkg;

    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int COORD_BITS     = 10;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_DATA_BITS-1:0] FRAME_HEIGHT_RST = 11'd480;
    localparam int MIN_DIM = 3;

    // Slope thresholds in Q16: tan(22.5 deg) and tan(67.5 deg).
    localparam int TAN_LO_Q16 = 27146;
    localparam int TAN_HI_Q16 = 158218;
    localparam int SLOPE_FRAC_BITS = 16;

    typedef enum logic [1:0] {
        DIR_HORZ      = 2'd0,
        DIR_DIAG_DOWN = 2'd1,
        DIR_DIAG_UP   = 2'd2,
        DIR_VERT      = 2'd3
    } dir_t;

endpackage

### rtl/enms_if.sv
// ----------------------------------------------------------------------------
// Edge non-maximum suppression channels
// Valid/ready channels for pixels in, decisions out and register writes.
// ----------------------------------------------------------------------------
interface enms_pix_if #(
    parameter int MAG_BITS  = 16,
    parameter int GRAD_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic [MAG_BITS-1:0]         magnitude;
    logic signed [GRAD_BITS-1:0] grad_x;
    logic signed [GRAD_BITS-1:0] grad_y;

    modport source (output valid, magnitude, grad_x, grad_y, input ready);
    modport sink   (input valid, magnitude, grad_x, grad_y, output ready);
endinterface

interface enms_res_if;
    import enms_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;
    logic                  is_peak;
    logic                  end_of_frame;

    modport source (output valid, pixel_row, pixel_col, is_peak, end_of_frame,
                    input ready);
    modport sink   (input valid, pixel_row, pixel_col, is_peak, end_of_frame,
                    output ready);
endinterface

interface enms_cfg_if;
    import enms_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/edge_non_maximum_suppression.sv
// ----------------------------------------------------------------------------
// Edge non-maximum suppression
// Canny 3x3 suppression over a raster stream of magnitude and gradients.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless the output stalls, and gives one
// decision per interior pixel once the pixel one row down and one column right
// of it has passed the registered pipeline; border pixels give no result. One
// line memory holds the two previous magnitude rows and the previous gradient
// row, and each pixel does a single read and write back of its column, which
// sets the rate at one pixel per clock. Line contents are never used before
// the current frame refills them, so no clearing pass runs after reset. A
// register write restarts the frame at row 0, column 0.
`include "assert_macros.svh"

module edge_non_maximum_suppression #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAG_BITS   = 16,
    parameter int GRAD_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    enms_pix_if.sink    pixels,
    enms_res_if.source  results,
    enms_cfg_if.sink    cfg
);
    import enms_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DMAX  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DWA   = $clog2(DMAX + 1);
    localparam int DW    = (DWA > CFG_DATA_BITS) ? DWA : CFG_DATA_BITS;
    localparam int RAM_W = 2 * MAG_BITS + 2 * GRAD_BITS;
    localparam int PW    = GRAD_BITS + 20;
    localparam int LOW   = GRAD_BITS + 15;
    localparam int HIW   = GRAD_BITS + 18;

    // Configuration and frame position.
    logic [CFG_DATA_BITS-1:0] frame_width_reg, frame_height_reg;
    logic [CW-1:0]            col_reg, col_next;
    logic [RW-1:0]            row_reg, row_next;
    logic                     cfg_hit;

    logic [DW-1:0] w_eff, h_eff, fw_ext, fh_ext;
    logic [DW-1:0] c_cur, r_cur, c_step, r_step;
    logic          adv, accept, emit_now, eof_now, last_px;

    // Line memory port.
    logic              ram_we, ram_re;
    logic [CW-1:0]     ram_waddr, ram_raddr;
    logic [RAM_W-1:0]  ram_wdata, ram_rdata;

    // Stage 1: memory data available, window shift.
    logic                  s1_valid_reg, s1_emit_reg, s1_eof_reg;
    logic [MAG_BITS-1:0]   s1_mag_reg;
    logic [GRAD_BITS-1:0]  s1_gx_reg, s1_gy_reg;
    logic [COORD_BITS-1:0] s1_row_reg, s1_col_reg;
    logic [CW-1:0]         s1_addr_reg;

    logic [MAG_BITS-1:0]  win_reg [3][2];
    logic [GRAD_BITS-1:0] hold_gx_reg, hold_gy_reg;

    logic [MAG_BITS-1:0]  rd_la, rd_lb, ctr;
    logic [GRAD_BITS-1:0] rd_gx, rd_gy;
    logic [3:0]           cand;
    logic                 gx_neg;
    logic [GRAD_BITS-1:0] gx_abs;
    logic signed [GRAD_BITS:0] gy_ext, gy_adj;

    // Stage 2: slope products.
    logic                      s2_valid_reg, s2_eof_reg, s2_gx_zero_reg, s2_gy_zero_reg;
    logic [COORD_BITS-1:0]     s2_row_reg, s2_col_reg;
    logic [3:0]                s2_cand_reg;
    logic [GRAD_BITS-1:0]      s2_gx_abs_reg;
    logic signed [GRAD_BITS:0] s2_gy_adj_reg;
    logic [LOW-1:0]            lo_prod;
    logic [HIW-1:0]            hi_prod;

    // Stage 3: direction bucket and selection.
    logic                  s3_valid_reg, s3_eof_reg, s3_gx_zero_reg, s3_gy_zero_reg;
    logic [COORD_BITS-1:0] s3_row_reg, s3_col_reg;
    logic [3:0]            s3_cand_reg;
    logic signed [PW-1:0]  s3_s_reg, s3_lo_reg, s3_hi_reg;
    logic signed [PW-1:0]  neg_lo, neg_hi;
    dir_t                  dir;
    logic                  peak;

    // Output register.
    logic                  out_valid_reg, out_peak_reg, out_eof_reg;
    logic [COORD_BITS-1:0] out_row_reg, out_col_reg;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign cfg.ready = 1'b1;
    assign cfg_hit   = cfg.valid &&
                       (cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Frame position and request acceptance
    // ------------------------------------------------------------------------
    assign adv           = !out_valid_reg || results.ready;
    assign pixels.ready  = adv;
    assign accept        = pixels.valid && adv;

    assign fw_ext = DW'(frame_width_reg);
    assign fh_ext = DW'(frame_height_reg);

    always_comb
    begin
        if (fw_ext < DW'(MIN_DIM))
            w_eff = DW'(MIN_DIM);
        else if (fw_ext > DW'(MAX_WIDTH))
            w_eff = DW'(MAX_WIDTH);
        else
            w_eff = fw_ext;

        if (fh_ext < DW'(MIN_DIM))
            h_eff = DW'(MIN_DIM);
        else if (fh_ext > DW'(MAX_HEIGHT))
            h_eff = DW'(MAX_HEIGHT);
        else
            h_eff = fh_ext;

        c_cur = (DW'(col_reg) >= w_eff) ? '0 : DW'(col_reg);
        r_cur = (DW'(row_reg) >= h_eff) ? '0 : DW'(row_reg);
        c_step = c_cur + 1'b1;
        r_step = r_cur + 1'b1;

        if (c_step >= w_eff)
        begin
            col_next = '0;
            row_next = (r_step >= h_eff) ? '0 : r_step[RW-1:0];
        end
        else
        begin
            col_next = c_step[CW-1:0];
            row_next = r_cur[RW-1:0];
        end
    end

    assign emit_now = (r_cur >= DW'(2)) && (c_cur >= DW'(2));
    assign last_px  = (r_cur == h_eff - 1'b1) && (c_cur == w_eff - 1'b1);
    assign eof_now  = last_px;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------------
    // Line memory: {newest magnitude row, older magnitude row, gx, gy}
    // ------------------------------------------------------------------------
    assign ram_re    = accept;
    assign ram_raddr = c_cur[CW-1:0];
    assign ram_we    = s1_valid_reg && adv;
    assign ram_waddr = s1_addr_reg;
    assign ram_wdata = {s1_mag_reg, rd_la, s1_gx_reg, s1_gy_reg};

    enms_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign {rd_la, rd_lb, rd_gx, rd_gy} = ram_rdata;

    // ------------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mag_reg  <= pixels.magnitude;
            s1_gx_reg   <= pixels.grad_x;
            s1_gy_reg   <= pixels.grad_y;
            s1_emit_reg <= emit_now;
            s1_eof_reg  <= eof_now;
            s1_row_reg  <= COORD_BITS'(r_cur - 1'b1);
            s1_col_reg  <= COORD_BITS'(c_cur - 1'b1);
            s1_addr_reg <= c_cur[CW-1:0];
        end
    end

    // The window keeps two columns; the third comes straight from the memory and the stage 1 pixel register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= '0;
                win_reg[k][1] <= '0;
            end
            hold_gx_reg <= '0;
            hold_gy_reg <= '0;
        end
        else if (s1_valid_reg && adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= win_reg[k][1];
            end
            win_reg[0][1] <= rd_lb;
            win_reg[1][1] <= rd_la;
            win_reg[2][1] <= s1_mag_reg;
            hold_gx_reg   <= rd_gx;
            hold_gy_reg   <= rd_gy;
        end
    end

    assign ctr = win_reg[1][1];

    always_comb
    begin
        cand[DIR_HORZ]      = (ctr > win_reg[1][0]) && (ctr > rd_la);
        cand[DIR_DIAG_DOWN] = (ctr > win_reg[0][0]) && (ctr > s1_mag_reg);
        cand[DIR_DIAG_UP]   = (ctr > win_reg[2][0]) && (ctr > rd_lb);
        cand[DIR_VERT]      = (ctr > win_reg[0][1]) && (ctr > win_reg[2][1]);

        gx_neg = hold_gx_reg[GRAD_BITS-1];
        gx_abs = gx_neg ? (~hold_gx_reg + 1'b1) : hold_gx_reg;
        gy_ext = {hold_gy_reg[GRAD_BITS-1], hold_gy_reg};
        gy_adj = gx_neg ? -gy_ext : gy_ext;
    end

    // ------------------------------------------------------------------------
    // Stage 2
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_eof_reg     <= s1_eof_reg;
            s2_row_reg     <= s1_row_reg;
            s2_col_reg     <= s1_col_reg;
            s2_cand_reg    <= cand;
            s2_gx_abs_reg  <= gx_abs;
            s2_gy_adj_reg  <= gy_adj;
            s2_gx_zero_reg <= (hold_gx_reg == '0);
            s2_gy_zero_reg <= (hold_gy_reg == '0);
        end
    end

    assign lo_prod = LOW'(s2_gx_abs_reg) * LOW'(TAN_LO_Q16);
    assign hi_prod = HIW'(s2_gx_abs_reg) * HIW'(TAN_HI_Q16);

    // ------------------------------------------------------------------------
    // Stage 3
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_eof_reg     <= s2_eof_reg;
            s3_row_reg     <= s2_row_reg;
            s3_col_reg     <= s2_col_reg;
            s3_cand_reg    <= s2_cand_reg;
            s3_gx_zero_reg <= s2_gx_zero_reg;
            s3_gy_zero_reg <= s2_gy_zero_reg;
            s3_s_reg       <= PW'(s2_gy_adj_reg) <<< SLOPE_FRAC_BITS;
            s3_lo_reg      <= $signed(PW'(lo_prod));
            s3_hi_reg      <= $signed(PW'(hi_prod));
        end
    end

    assign neg_lo = -s3_lo_reg;
    assign neg_hi = -s3_hi_reg;

    always_comb
    begin
        if (s3_gx_zero_reg)
            dir = s3_gy_zero_reg ? DIR_HORZ : DIR_VERT;
        else if (s3_s_reg <= s3_lo_reg && s3_s_reg > neg_lo)
            dir = DIR_HORZ;
        else if (s3_s_reg <= s3_hi_reg && s3_s_reg > s3_lo_reg)
            dir = DIR_DIAG_DOWN;
        else if (s3_s_reg <= neg_lo && s3_s_reg > neg_hi)
            dir = DIR_DIAG_UP;
        else
            dir = DIR_VERT;

        case (dir)
            DIR_HORZ:      peak = s3_cand_reg[DIR_HORZ];
            DIR_DIAG_DOWN: peak = s3_cand_reg[DIR_DIAG_DOWN];
            DIR_DIAG_UP:   peak = s3_cand_reg[DIR_DIAG_UP];
            default:       peak = s3_cand_reg[DIR_VERT];
        endcase
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg)
        begin
            out_row_reg  <= s3_row_reg;
            out_col_reg  <= s3_col_reg;
            out_peak_reg <= peak;
            out_eof_reg  <= s3_eof_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.pixel_row    = out_row_reg;
    assign results.pixel_col    = out_col_reg;
    assign results.is_peak      = out_peak_reg;
    assign results.end_of_frame = out_eof_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_NEVER(a_ram_same_entry, clk, rst_n, ram_we && ram_re && (ram_waddr == ram_raddr))
    `ASSERT_CLK(a_accept_fills_s1, clk, rst_n, accept |=> s1_valid_reg)
    `ASSERT_CLK(a_frame_wrap, clk, rst_n, (accept && last_px) |=> (col_reg == '0 && row_reg == '0))

endmodule

### rtl/enms_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module enms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### sim/enms_decision_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Suppression decision checker
// Watches the register, pixel and decision channels, keeps its own model of
// the line buffers and 3x3 window, and compares every decision it sees.
// ----------------------------------------------------------------------------
module enms_decision_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic clk,
    input  logic rst_n,
    enms_pix_if  pixels,
    enms_res_if  results,
    enms_cfg_if  cfg,
    output int   fail_count,
    output int   outstanding,
    output int   decisions_checked,
    output int   peaks_seen,
    output int   frames_seen
);
    import enms_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  peak;
        logic                  eof;
    } decision_t;

    decision_t expected_decisions[$];

    logic [15:0] mag_row_above [MAX_WIDTH];
    logic [15:0] mag_row_above2 [MAX_WIDTH];
    logic [15:0] gx_row_above [MAX_WIDTH];
    logic [15:0] gy_row_above [MAX_WIDTH];
    logic [15:0] window [9];
    logic [15:0] held_gx;
    logic [15:0] held_gy;
    int unsigned col_pos;
    int unsigned row_pos;
    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;
    int errors;
    int checked;
    int peaks;
    int frames;

    function automatic int unsigned usable_dim(logic [CFG_DATA_BITS-1:0] v,
                                               int unsigned limit);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic dir_t gradient_direction(logic signed [15:0] gx_raw,
                                                logic signed [15:0] gy_raw);
        longint gx = gx_raw;
        longint gy = gy_raw;
        longint slope;
        longint lo;
        longint hi;
        if (gx == 0)
            return (gy == 0) ? DIR_HORZ : DIR_VERT;
        if (gx < 0)
        begin
            gx = -gx;
            gy = -gy;
        end
        slope = gy * (longint'(1) << SLOPE_FRAC_BITS);
        lo = longint'(TAN_LO_Q16) * gx;
        hi = longint'(TAN_HI_Q16) * gx;
        if (slope <= lo && slope > -lo)
            return DIR_HORZ;
        if (slope <= hi && slope > lo)
            return DIR_DIAG_DOWN;
        if (slope <= -lo && slope > -hi)
            return DIR_DIAG_UP;
        return DIR_VERT;
    endfunction

    function automatic int field_check(string label, logic [9:0] want, logic [9:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic advance_pixel(input logic [15:0] mag, input logic [15:0] gx_in,
                                 input logic [15:0] gy_in);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic [15:0] center_gx;
        logic [15:0] center_gy;
        logic [15:0] side_a;
        logic [15:0] side_b;
        decision_t d;
        w = usable_dim(width_reg, MAX_WIDTH);
        h = usable_dim(height_reg, MAX_HEIGHT);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        center_gx = held_gx;
        center_gy = held_gy;

        for (int k = 0; k < 3; k++)
        begin
            window[k * 3 + 0] = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2] = mag_row_above2[c];
        window[5] = mag_row_above[c];
        window[8] = mag;
        mag_row_above2[c] = mag_row_above[c];
        mag_row_above[c] = mag;

        held_gx = gx_row_above[c];
        held_gy = gy_row_above[c];
        gx_row_above[c] = gx_in;
        gy_row_above[c] = gy_in;

        if (r >= 2 && c >= 2)
        begin
            case (gradient_direction(center_gx, center_gy))
                DIR_HORZ:      begin side_a = window[3]; side_b = window[5]; end
                DIR_DIAG_DOWN: begin side_a = window[0]; side_b = window[8]; end
                DIR_DIAG_UP:   begin side_a = window[6]; side_b = window[2]; end
                default:       begin side_a = window[1]; side_b = window[7]; end
            endcase
            d.row = COORD_BITS'(r - 1);
            d.col = COORD_BITS'(c - 1);
            d.peak = (window[4] > side_a) && (window[4] > side_b);
            d.eof = (r == h - 1) && (c == w - 1);
            expected_decisions.insert(expected_decisions.size(), d);
        end

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decision_t want;
        int bad;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                mag_row_above[i] = '0;
                mag_row_above2[i] = '0;
                gx_row_above[i] = '0;
                gy_row_above[i] = '0;
            end
            for (int i = 0; i < 9; i++)
                window[i] = '0;
            held_gx = '0;
            held_gy = '0;
            col_pos = 0;
            row_pos = 0;
            width_reg = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            expected_decisions.delete();
            errors = 0;
            checked = 0;
            peaks = 0;
            frames = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT)
                begin
                    if (cfg.index == REG_FRAME_WIDTH)
                        width_reg = cfg.data;
                    else
                        height_reg = cfg.data;
                    col_pos = 0;
                    row_pos = 0;
                end
            end
            if (results.valid && results.ready)
            begin
                if (expected_decisions.size() == 0)
                begin
                    $display("%0t: decision row %0d col %0d arrived, none expected",
                             $time, results.pixel_row, results.pixel_col);
                    errors++;
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    bad = field_check("pixel_row", want.row, results.pixel_row)
                        + field_check("pixel_col", want.col, results.pixel_col)
                        + field_check("is_peak", want.peak, results.is_peak)
                        + field_check("end_of_frame", want.eof, results.end_of_frame);
                    errors += bad;
                    checked++;
                    if (want.peak)
                        peaks++;
                    if (want.eof)
                        frames++;
                end
            end
            if (pixels.valid && pixels.ready)
                advance_pixel(pixels.magnitude, pixels.grad_x, pixels.grad_y);
        end
        fail_count <= errors;
        outstanding <= expected_decisions.size();
        decisions_checked <= checked;
        peaks_seen <= peaks;
        frames_seen <= frames;
    end

endmodule

### sim/edge_non_maximum_suppression_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edge non-maximum suppression testbench
// Streams directed and random pixel frames through several frame sizes,
// including clamped and maximum sizes, with random idling on both channels.
// ----------------------------------------------------------------------------
module edge_non_maximum_suppression_tb;
    import enms_pkg::*;

    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DEFAULT_ITEMS    = 40;

    localparam int DIR_TEST_GX [10] = '{5, 0, 0, 32767, -32768, -32768, -32768, 1, 1, -7};
    localparam int DIR_TEST_GY [10] = '{0, 0, -32768, 32767, 32767, -13573, 13573, 2, 3, 9};
    localparam logic [15:0] DIR_TEST_MAG [7] = '{16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF,
                                                 16'h0001, 16'h8000, 16'h7FFF};

    typedef struct packed {
        logic [15:0]        mag;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   calm = 1'b0;
    int   hold_requests = 0;
    int   items_sent = 0;
    int   reg_writes = 0;
    int   fail_count;
    int   outstanding;
    int   decisions_checked;
    int   peaks_seen;
    int   frames_seen;

    enms_pix_if #(.MAG_BITS(16), .GRAD_BITS(16)) pix_ch ();
    enms_res_if res_ch ();
    enms_cfg_if cfg_ch ();

    edge_non_maximum_suppression uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    enms_decision_checker decision_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .pixels            (pix_ch),
        .results           (res_ch),
        .cfg               (cfg_ch),
        .fail_count        (fail_count),
        .outstanding       (outstanding),
        .decisions_checked (decisions_checked),
        .peaks_seen        (peaks_seen),
        .frames_seen       (frames_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] edge_value();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int     k;
        int     gx_mag;
        longint gy_l;
        case ($urandom_range(0, 3))
            0:       p.mag = 16'($urandom_range(0, 3));
            1:       p.mag = 16'($urandom);
            2:       p.mag = edge_value();
            default: p.mag = {8'($urandom), 8'h00};
        endcase
        case ($urandom_range(0, 3))
            0:
            begin
                p.gx = 16'(int'($urandom_range(0, 6)) - 3);
                p.gy = 16'(int'($urandom_range(0, 6)) - 3);
            end
            1:
            begin
                p.gx = 16'($urandom);
                p.gy = 16'($urandom);
            end
            2:
            begin
                p.gx = edge_value();
                p.gy = edge_value();
            end
            default:
            begin
                k = $urandom_range(0, 1) ? TAN_HI_Q16 : TAN_LO_Q16;
                gx_mag = $urandom_range(1, 12000);
                gy_l = (longint'(gx_mag) * k) / 65536 + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    gy_l = -gy_l;
                p.gx = $urandom_range(0, 1) ? 16'(-gx_mag) : 16'(gx_mag);
                p.gy = 16'(gy_l);
            end
        endcase
        return p;
    endfunction

    task automatic wait_drained();
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        reg_writes++;
    endtask

    task automatic send_pixel(input pixel_t p);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.magnitude <= p.mag;
        pix_ch.grad_x <= p.gx;
        pix_ch.grad_y <= p.gy;
        do @(posedge clk); while (!pix_ch.ready);
        items_sent++;
    endtask

    task automatic run_phase(input bit set_w, input logic [CFG_DATA_BITS-1:0] w,
                             input bit set_h, input logic [CFG_DATA_BITS-1:0] h,
                             input int count, input bit directed, input bit squeeze);
        pixel_t p;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (set_w || set_h)
        begin
            if (set_w)
                write_reg(REG_FRAME_WIDTH, w);
            if (set_h)
                write_reg(REG_FRAME_HEIGHT, h);
            cfg_ch.valid <= 1'b0;
        end
        for (int i = 0; i < count; i++)
        begin
            if (squeeze && i == 20)
                hold_requests++;
            if (squeeze && i == count / 2)
            begin
                pix_ch.valid <= 1'b0;
                wait_drained();
            end
            if (directed)
            begin
                p.mag = DIR_TEST_MAG[i % 7];
                p.gx = 16'(DIR_TEST_GX[i / 3]);
                p.gy = 16'(DIR_TEST_GY[i / 3]);
            end
            else
                p = random_pixel();
            send_pixel(p);
        end
        pix_ch.valid <= 1'b0;
    endtask

    initial
    begin : result_sink
        int holds_done = 0;
        forever
        begin
            if (hold_requests > holds_done)
            begin
                holds_done++;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        pix_ch.valid <= 1'b0;
        pix_ch.magnitude <= '0;
        pix_ch.grad_x <= '0;
        pix_ch.grad_y <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_FRAME_WIDTH;
        cfg_ch.data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        run_phase(1'b0, '0, 1'b0, '0, DEFAULT_ITEMS, 1'b0, 1'b0);
        run_phase(1'b1, 11'd3, 1'b1, 11'd10, 30, 1'b1, 1'b0);
        run_phase(1'b1, 11'd5, 1'b1, 11'd4, 60, 1'b0, 1'b0);
        run_phase(1'b1, 11'd0, 1'b1, 11'd1, 45, 1'b0, 1'b0);
        run_phase(1'b1, 11'd7, 1'b1, 11'd5, 70, 1'b0, 1'b0);
        run_phase(1'b0, '0, 1'b1, 11'd6, 84, 1'b0, 1'b0);
        run_phase(1'b1, 11'd10, 1'b1, 11'd8, 160, 1'b0, 1'b1);
        run_phase(1'b1, 11'd16, 1'b1, 11'd3, 96, 1'b0, 1'b0);
        run_phase(1'b1, 11'd2047, 1'b1, 11'd2, 40, 1'b0, 1'b0);
        run_phase(1'b1, 11'd3, 1'b1, 11'd1024, 60, 1'b0, 1'b0);
        calm = 1'b1;
        run_phase(1'b1, 11'd6, 1'b1, 11'd5, 60, 1'b0, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Streamed %0d pixels over %0d register writes, frame sizes from 3 to 1024",
                 items_sent, reg_writes);
        $display("with clamped settings; checked %0d decisions, %0d peaks, %0d frame ends.",
                 decisions_checked, peaks_seen, frames_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/enms_pkg.sv
rtl/enms_if.sv
rtl/enms_ram.sv
rtl/edge_non_maximum_suppression.sv
sim/enms_decision_checker.sv
sim/edge_non_maximum_suppression_tb.sv
